// ===== rtl/sma_pkg.sv =====
`timescale 1ns / 1ps

package sma_pkg;

  // default number of stack entries
  localparam int unsigned StackDepthDef = 64;

  // fixed field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned DepthW  = 7;
  localparam int unsigned StatusW = 2;

  // shared adder width: data plus two guard bits for signed compare and divide steps
  localparam int unsigned AddW = DataW + 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 3'd0,
    CMD_MUL   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_PUSH  = 3'd4,
    CMD_CMP   = 3'd5,
    CMD_CLEAR = 3'd6
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

endpackage

// ===== rtl/stack_machine_alu.sv =====
`timescale 1ns / 1ps

// 32-bit reverse-polish stack machine: each input word is one instruction (push, clear, or a
// binary add/multiply/subtract/divide/compare on the two top entries) and each instruction
// returns exactly one output word carrying the new top of stack (zero when empty), the depth
// and a status code. The top of stack lives in a register and the entries below it in an
// internal memory with one write and one registered read port, so no clearing pass is needed
// after reset. All arithmetic goes through one shared 34-bit adder under a small sequencer.
// With the output free, push, clear and any rejected instruction go straight to the completion
// state; add, subtract and compare go through a memory read and the adder state, multiply
// through a read and shift-and-add (one bit per cycle), and divide through a read, sign removal,
// 32 restoring steps and a sign fix-up. The input goes ready in the same cycle as the output
// word appears. The input stalls while an instruction is in flight; a finished output word may
// wait in its register while the next instruction is taken.
module stack_machine_alu #(
  parameter int unsigned STACK_DEPTH = sma_pkg::StackDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sma_pkg::CmdW-1:0]         command_i,
  input  logic signed [sma_pkg::DataW-1:0] immediate_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [sma_pkg::DataW-1:0] top_value_o,
  output logic [sma_pkg::DepthW-1:0]       depth_o,
  output logic [sma_pkg::StatusW-1:0]      status_o
);

  localparam int unsigned DW = sma_pkg::DataW;
  localparam int unsigned AW = sma_pkg::AddW;
  // count must hold the full depth itself
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned IterW = $clog2(DW);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_ALU   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_NEG_S = 4'd4;
  localparam logic [3:0] S_NEG_T = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIX   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q;

  // stack state: top in a register, lower entries in memory
  logic [CntW-1:0]     count_q;
  logic [DW-1:0]       top_q;
  logic [DW-1:0]       mem [STACK_DEPTH];
  logic [DW-1:0]       rd_q;

  // operand / working registers
  sma_pkg::cmd_e       cmd_q;
  sma_pkg::status_e    status_q;
  logic [DW-1:0]       a_q;     // second operand, then multiplicand or dividend/quotient
  logic [DW-1:0]       b_q;     // first operand, then multiplier or divisor magnitude
  logic [DW-1:0]       acc_q;   // product accumulator or partial remainder
  logic [IterW-1:0]    iter_q;
  logic                neg_q;   // quotient sign

  // output word register
  logic                out_valid_q;
  logic [DW-1:0]       out_top_q;
  logic [sma_pkg::DepthW-1:0]  out_depth_q;
  logic [sma_pkg::StatusW-1:0] out_status_q;

  // shared adder
  logic [AW-1:0] add_x, add_y, add_sum;
  logic          add_sub;

  logic                in_acc;
  sma_pkg::cmd_e       in_cmd;
  logic [CntW-1:0]     cnt_m1, cnt_m2;
  logic                mem_we;
  logic [AddrW-1:0]    waddr, raddr;
  logic                out_free;
  logic [DW-1:0]       cmp_res;
  logic [AW-1:0]       div_part;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_cmd     = sma_pkg::cmd_e'(command_i);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_q - CntW'(2);
  assign waddr  = cnt_m1[AddrW-1:0];
  assign raddr  = cnt_m2[AddrW-1:0];

  // on push the old top moves down into memory
  assign mem_we = in_acc && (in_cmd == sma_pkg::CMD_PUSH) &&
                  (count_q != CntW'(STACK_DEPTH)) && (count_q != '0);

  // partial remainder with the next dividend bit shifted in
  assign div_part = {1'b0, acc_q, a_q[DW-1]};

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      S_ALU: begin
        add_x   = {{2{a_q[DW-1]}}, a_q};
        add_y   = {{2{b_q[DW-1]}}, b_q};
        add_sub = (cmd_q != sma_pkg::CMD_ADD);
      end
      S_MUL: begin
        add_x = {2'b00, acc_q};
        add_y = {2'b00, a_q};
      end
      S_NEG_S: begin
        add_y   = {2'b00, a_q};
        add_sub = 1'b1;
      end
      S_NEG_T: begin
        add_y   = {2'b00, b_q};
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_x   = div_part;
        add_y   = {2'b00, b_q};
        add_sub = 1'b1;
      end
      S_FIX: begin
        add_y   = {2'b00, a_q};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    add_sum = add_x + (add_y ^ {AW{add_sub}}) + AW'(add_sub);
  end

  // signed compare: 1 when first operand above second, -1 when below
  always_comb begin
    if (add_sum == '0) begin
      cmp_res = '0;
    end else if (add_sum[AW-1]) begin
      cmp_res = DW'(1);
    end else begin
      cmp_res = '1;
    end
  end

  // stack memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= top_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
  end

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      top_q    <= '0;
      a_q      <= '0;
      b_q      <= '0;
      acc_q    <= '0;
      cmd_q    <= sma_pkg::CMD_ADD;
      status_q <= sma_pkg::ST_OK;
      iter_q   <= '0;
      neg_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q    <= in_cmd;
            status_q <= sma_pkg::ST_OK;
            state_q  <= S_DONE;
            case (in_cmd)
              sma_pkg::CMD_PUSH: begin
                if (count_q == CntW'(STACK_DEPTH)) begin
                  status_q <= sma_pkg::ST_OVER;
                end else begin
                  top_q   <= immediate_i;
                  count_q <= count_q + CntW'(1);
                end
              end
              sma_pkg::CMD_CLEAR: begin
                count_q <= '0;
              end
              sma_pkg::CMD_ADD, sma_pkg::CMD_MUL, sma_pkg::CMD_SUB,
              sma_pkg::CMD_DIV, sma_pkg::CMD_CMP: begin
                if (count_q < CntW'(2)) begin
                  status_q <= sma_pkg::ST_UNDER;
                end else if ((in_cmd == sma_pkg::CMD_DIV) && (top_q == '0)) begin
                  status_q <= sma_pkg::ST_DIVZ;
                end else begin
                  state_q <= S_READ;   // memory read of the second entry is in flight
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          a_q    <= rd_q;
          b_q    <= top_q;
          acc_q  <= '0;
          iter_q <= '0;
          case (cmd_q)
            sma_pkg::CMD_MUL: state_q <= S_MUL;
            sma_pkg::CMD_DIV: state_q <= S_NEG_S;
            default:          state_q <= S_ALU;
          endcase
        end
        S_ALU: begin
          top_q   <= (cmd_q == sma_pkg::CMD_CMP) ? cmp_res : add_sum[DW-1:0];
          count_q <= cnt_m1;
          state_q <= S_DONE;
        end
        S_MUL: begin
          // shift-and-add, low word only
          if (b_q[0]) begin
            acc_q <= add_sum[DW-1:0];
          end
          a_q    <= {a_q[DW-2:0], 1'b0};
          b_q    <= {1'b0, b_q[DW-1:1]};
          iter_q <= iter_q + IterW'(1);
          if (iter_q == IterW'(DW - 1)) begin
            top_q   <= b_q[0] ? add_sum[DW-1:0] : acc_q;
            count_q <= cnt_m1;
            state_q <= S_DONE;
          end
        end
        S_NEG_S: begin
          neg_q <= a_q[DW-1] ^ b_q[DW-1];
          if (a_q[DW-1]) begin
            a_q <= add_sum[DW-1:0];
          end
          state_q <= S_NEG_T;
        end
        S_NEG_T: begin
          if (b_q[DW-1]) begin
            b_q <= add_sum[DW-1:0];
          end
          acc_q   <= '0;
          iter_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring step: keep the difference when it did not go negative
          if (!add_sum[AW-1]) begin
            acc_q <= add_sum[DW-1:0];
          end else begin
            acc_q <= div_part[DW-1:0];
          end
          a_q    <= {a_q[DW-2:0], ~add_sum[AW-1]};
          iter_q <= iter_q + IterW'(1);
          if (iter_q == IterW'(DW - 1)) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          top_q   <= neg_q ? add_sum[DW-1:0] : a_q;
          count_q <= cnt_m1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // output word register, loaded once the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      out_top_q    <= (count_q != '0) ? top_q : '0;
      out_depth_q  <= sma_pkg::DepthW'(count_q);
      out_status_q <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;
  assign status_o    = out_status_q;

`ifndef SYNTHESIS
  // stack never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("stack count above capacity");

  // depth moves by at most one per instruction step, or drops to zero on clear
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) && (count_q != '0) |->
      (count_q == $past(count_q) + CntW'(1)) || (count_q == $past(count_q) - CntW'(1)))
    else $error("stack count jumped");

  // a new output word only comes out of the completion state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("output word raised outside completion");

  // partial remainder stays below the divisor magnitude
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (acc_q < b_q))
    else $error("divide remainder not below divisor");
`endif

endmodule
